@@ rtl/assert_macros.svh @@
// assertion macros included by the rtl core
// assumes clk and rst_n (active low) exist in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define OOTLC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define OOTLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ootlc_pkg.sv @@
// shared types and constants for the on/off timed light control core
// no dependencies
`timescale 1ns / 1ps

package ootlc_pkg;

  // counter width default
  localparam int TIME_BITS_DEF = 16;

  // command codes, code 7 is unused
  typedef enum logic [2:0] {
    ACT_ON         = 3'd0,
    ACT_OFF        = 3'd1,
    ACT_TOGGLE     = 3'd2,
    ACT_OFF_EFFECT = 3'd3,
    ACT_RECALL     = 3'd4,
    ACT_TIMED_OFF  = 3'd5,
    ACT_TICK       = 3'd6
  } action_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_TIME_SUP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_WAIT_SUP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DESIRED_UPD  = 2'd2;

  // off effect identifiers and variants
  localparam logic [7:0] EFFECT_DELAYED_OFF = 8'd0;
  localparam logic [7:0] EFFECT_DYING_LIGHT = 8'd1;
  localparam logic [7:0] VARIANT_0          = 8'd0;
  localparam logic [7:0] VARIANT_1          = 8'd1;
  localparam logic [7:0] VARIANT_2          = 8'd2;

  // level block request values
  localparam logic [7:0] LEVEL_OFF  = 8'd0;
  localparam logic [7:0] HALF_LEVEL = 8'd128;
  localparam logic [7:0] SHORT_FADE = 8'd8;
  localparam logic [7:0] DYING_FADE = 8'd12;
  localparam logic [7:0] NO_FADE    = 8'd0;

  // guard bit of the timed-off control field
  localparam logic TIMED_OFF_GUARD_BIT = 1'b1;

endpackage

@@ rtl/on_off_timed_light_control_core.sv @@
// on/off cluster server core: command decode, timed-off counters, result register
// depends on ootlc_pkg and assert_macros.svh
`timescale 1ns / 1ps

// Single-endpoint on/off light server. Each input transaction is one command
// (on, off, toggle, off with effect, recall scene, timed off) or one 100 ms
// tick, and yields exactly one result transaction with the state after the
// command plus level and scene pulses. The state update is one compare/decrement
// step feeding the state registers and the result register, so a new command
// is taken each cycle while the result register is empty or being drained.
// in_stall rises only while a result is held by out_stall. Configuration is
// written through cfg_* (always ready) and must only change while no command
// is in flight. Counters are TIME_BITS wide; reported counts saturate at 65535.
module on_off_timed_light_control_core #(
  parameter int TIME_BITS = ootlc_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ootlc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_wdata,
  // command channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     in_action,
  input  logic                           in_accept_only_when_on,
  input  logic [15:0]                    in_on_time_arg,
  input  logic [15:0]                    in_off_wait_arg,
  input  logic [7:0]                     in_effect_id,
  input  logic [7:0]                     in_effect_variant,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_light_on,
  output logic [15:0]                    out_on_time_now,
  output logic [15:0]                    out_off_wait_now,
  output logic                           out_scene_control,
  output logic                           out_timer_running,
  output logic                           out_level_request,
  output logic [7:0]                     out_level_target,
  output logic [7:0]                     out_level_transition,
  output logic                           out_store_scene,
  output logic                           out_recall_scene
);
  import ootlc_pkg::*;

  `include "assert_macros.svh"

  localparam logic [31:0] TimeMax = 32'((64'd1 << TIME_BITS) - 64'd1);
  localparam logic [31:0] OutMax  = 32'h0000_FFFF;

  typedef logic [TIME_BITS-1:0] time_t;

  // configuration registers
  logic  on_time_sup_r, off_wait_sup_r, desired_upd_r;
  // server state
  logic  on_r, scene_r, active_r;
  time_t on_cnt_r, wait_cnt_r;
  // next state
  logic  on_nxt, scene_nxt, active_nxt;
  time_t on_cnt_nxt, wait_cnt_nxt;
  // per-command pulses
  logic       req, store, recall;
  logic [7:0] target, trans;
  // clipped timed-off arguments
  time_t on_arg, wait_arg;
  logic  in_accept, out_accept;

  // result register
  logic        out_valid_r;
  logic        light_on_r, scene_ctl_r, timer_run_r;
  logic [15:0] on_time_now_r, off_wait_now_r;
  logic        level_req_r, store_r, recall_r;
  logic [7:0]  level_tgt_r, level_trn_r;
  logic [15:0] on_time_now_nxt, off_wait_now_nxt;

  assign cfg_ready  = 1'b1;
  assign in_stall   = out_valid_r & out_stall;
  assign in_accept  = in_valid & ~in_stall;
  assign out_accept = out_valid_r & ~out_stall;

  // configuration writes, unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_time_sup_r  <= 1'b1;
      off_wait_sup_r <= 1'b1;
      desired_upd_r  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ON_TIME_SUP:  on_time_sup_r  <= cfg_wdata;
        CFG_OFF_WAIT_SUP: off_wait_sup_r <= cfg_wdata;
        CFG_DESIRED_UPD:  desired_upd_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // saturate arguments to the counter width
  always_comb begin
    on_arg   = (32'(in_on_time_arg) > TimeMax) ? TimeMax[TIME_BITS-1:0]
                                               : TIME_BITS'(in_on_time_arg);
    wait_arg = (32'(in_off_wait_arg) > TimeMax) ? TimeMax[TIME_BITS-1:0]
                                                : TIME_BITS'(in_off_wait_arg);
  end

  // command decode and state update
  always_comb begin
    logic do_on, do_off;
    on_nxt       = on_r;
    scene_nxt    = scene_r;
    active_nxt   = active_r;
    on_cnt_nxt   = on_cnt_r;
    wait_cnt_nxt = wait_cnt_r;
    req          = 1'b0;
    store        = 1'b0;
    recall       = 1'b0;
    target       = LEVEL_OFF;
    trans        = NO_FADE;
    do_on        = 1'b0;
    do_off       = 1'b0;

    case (action_t'(in_action))
      ACT_ON:     do_on = 1'b1;
      ACT_OFF:    do_off = 1'b1;
      ACT_TOGGLE: begin
        do_off = on_r;
        do_on  = ~on_r;
      end
      ACT_OFF_EFFECT: begin
        if (scene_r) begin
          store      = 1'b1;
          scene_nxt  = 1'b0;
          on_cnt_nxt = '0;
        end
        if (in_effect_id == EFFECT_DELAYED_OFF && in_effect_variant == VARIANT_0) begin
          req = 1'b1; target = LEVEL_OFF; trans = SHORT_FADE;
        end else if (in_effect_id == EFFECT_DELAYED_OFF
                     && in_effect_variant == VARIANT_1) begin
          req = 1'b1; target = LEVEL_OFF; trans = NO_FADE;
        end else if (in_effect_id == EFFECT_DELAYED_OFF
                     && in_effect_variant == VARIANT_2) begin
          req = 1'b1; target = HALF_LEVEL; trans = SHORT_FADE;
        end else if (in_effect_id == EFFECT_DYING_LIGHT
                     && in_effect_variant == VARIANT_0) begin
          req = 1'b1; target = LEVEL_OFF; trans = DYING_FADE;
        end
        // move with on/off turns the light off at level zero
        if (req && target == LEVEL_OFF) on_nxt = 1'b0;
      end
      ACT_RECALL: begin
        if (!scene_r) begin
          on_nxt    = 1'b1;
          recall    = 1'b1;
          scene_nxt = 1'b1;
        end
      end
      ACT_TIMED_OFF: begin
        if (on_time_sup_r
            && !((in_accept_only_when_on & TIMED_OFF_GUARD_BIT) && !on_r)) begin
          if (wait_cnt_r != '0 && !on_r && wait_arg < wait_cnt_r) begin
            wait_cnt_nxt = wait_arg;
          end else begin
            if (on_arg > on_cnt_r) on_cnt_nxt = on_arg;
            if (desired_upd_r) on_nxt = 1'b1;
            wait_cnt_nxt = wait_arg;
          end
          if (wait_cnt_nxt != '0 && on_cnt_nxt != '0) active_nxt = 1'b1;
        end
      end
      ACT_TICK: begin
        if (active_r) begin
          if (on_r) begin
            if (on_cnt_r != '0) begin
              on_cnt_nxt = on_cnt_r - time_t'(1);
            end else begin
              wait_cnt_nxt = '0;
              on_nxt       = 1'b0;
              active_nxt   = 1'b0;
            end
          end else begin
            if (wait_cnt_r != '0) wait_cnt_nxt = wait_cnt_r - time_t'(1);
            else active_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase

    // plain on
    if (do_on) begin
      if (desired_upd_r) on_nxt = 1'b1;
      if (on_time_sup_r && off_wait_sup_r && on_cnt_r == '0) wait_cnt_nxt = '0;
    end
    // plain off, level zero with no fade
    if (do_off) begin
      if (desired_upd_r) begin
        on_nxt = 1'b0;
        req    = 1'b1;
      end
      if (on_time_sup_r) on_cnt_nxt = '0;
    end
  end

  // reported counts saturate at 16 bits
  always_comb begin
    on_time_now_nxt  = (32'(on_cnt_nxt) > OutMax) ? OutMax[15:0] : 16'(on_cnt_nxt);
    off_wait_now_nxt = (32'(wait_cnt_nxt) > OutMax) ? OutMax[15:0] : 16'(wait_cnt_nxt);
  end

  // server state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r       <= 1'b0;
      scene_r    <= 1'b1;
      active_r   <= 1'b0;
      on_cnt_r   <= '0;
      wait_cnt_r <= '0;
    end else if (in_accept) begin
      on_r       <= on_nxt;
      scene_r    <= scene_nxt;
      active_r   <= active_nxt;
      on_cnt_r   <= on_cnt_nxt;
      wait_cnt_r <= wait_cnt_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_accept) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, held while stalled
  always_ff @(posedge clk) begin
    if (in_accept) begin
      light_on_r     <= on_nxt;
      on_time_now_r  <= on_time_now_nxt;
      off_wait_now_r <= off_wait_now_nxt;
      scene_ctl_r    <= scene_nxt;
      timer_run_r    <= active_nxt;
      level_req_r    <= req;
      level_tgt_r    <= req ? target : LEVEL_OFF;
      level_trn_r    <= req ? trans : NO_FADE;
      store_r        <= store;
      recall_r       <= recall;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_light_on         = light_on_r;
  assign out_on_time_now      = on_time_now_r;
  assign out_off_wait_now     = off_wait_now_r;
  assign out_scene_control    = scene_ctl_r;
  assign out_timer_running    = timer_run_r;
  assign out_level_request    = level_req_r;
  assign out_level_target     = level_tgt_r;
  assign out_level_transition = level_trn_r;
  assign out_store_scene      = store_r;
  assign out_recall_scene     = recall_r;

  // consistency checks
  `OOTLC_ASSERT_IMPL(a_no_accept_when_held, out_valid_r && out_stall, in_stall, "command accepted over held result")
  `OOTLC_ASSERT_IMPL(a_level_zero_idle, out_valid_r && !level_req_r, level_tgt_r == LEVEL_OFF && level_trn_r == NO_FADE, "level fields set without request")
  `OOTLC_ASSERT_IMPL(a_store_clears_scene, out_valid_r && store_r, !scene_ctl_r && !recall_r, "scene store left scene control set")
  `OOTLC_ASSERT_NEXT(a_state_matches_result, in_accept, light_on_r == on_r && scene_ctl_r == scene_r && timer_run_r == active_r, "result differs from stored state")

endmodule

@@ dv/light_control_checker.sv @@
// checker for the on/off timed light control core: predicts each result and compares it
// depends on ootlc_pkg; watches the config, command and result channels of the core
`timescale 1ns / 1ps

module light_control_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [ootlc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                            cfg_wdata,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [2:0]                      in_action,
  input  logic                            in_accept_only_when_on,
  input  logic [15:0]                     in_on_time_arg,
  input  logic [15:0]                     in_off_wait_arg,
  input  logic [7:0]                      in_effect_id,
  input  logic [7:0]                      in_effect_variant,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            out_light_on,
  input  logic [15:0]                     out_on_time_now,
  input  logic [15:0]                     out_off_wait_now,
  input  logic                            out_scene_control,
  input  logic                            out_timer_running,
  input  logic                            out_level_request,
  input  logic [7:0]                      out_level_target,
  input  logic [7:0]                      out_level_transition,
  input  logic                            out_store_scene,
  input  logic                            out_recall_scene,
  output int                              mismatch_count,
  output int                              outstanding
);
  import ootlc_pkg::*;

  typedef struct packed {
    logic        light_on;
    logic [15:0] on_time;
    logic [15:0] off_wait;
    logic        scene_control;
    logic        timer_running;
    logic        level_request;
    logic [7:0]  level_target;
    logic [7:0]  level_transition;
    logic        store_scene;
    logic        recall_scene;
  } light_result_t;

  // predicted endpoint state and register copies
  logic        light_q;
  logic [15:0] on_time_q;
  logic [15:0] off_wait_q;
  logic        scene_q;
  logic        counting_q;
  logic        on_time_sup;
  logic        off_wait_sup;
  logic        desired_upd;

  light_result_t expected_light_q[$];
  int            errors;

  // on command: with on-time and off-wait support set, off-wait is dropped once on-time has run out
  function automatic void turn_on();
    if (desired_upd) light_q = 1'b1;
    if (on_time_sup && off_wait_sup && on_time_q == 16'd0) off_wait_q = 16'd0;
  endfunction

  // off command, returns the level request pulse
  function automatic logic turn_off();
    if (desired_upd) light_q = 1'b0;
    if (on_time_sup) on_time_q = 16'd0;
    return desired_upd;
  endfunction

  function automatic light_result_t predict_command(
    input logic [2:0]  act,
    input logic        guard,
    input logic [15:0] on_arg,
    input logic [15:0] wait_arg,
    input logic [7:0]  effect,
    input logic [7:0]  variant
  );
    light_result_t r;
    r = '0;
    case (act)
      ACT_ON: turn_on();
      ACT_OFF: r.level_request = turn_off();
      ACT_TOGGLE: begin
        if (light_q) r.level_request = turn_off();
        else turn_on();
      end
      ACT_OFF_EFFECT: begin
        // an off with effect while scene control is set saves the global scene
        if (scene_q) begin
          r.store_scene = 1'b1;
          scene_q = 1'b0;
          on_time_q = 16'd0;
        end
        if (effect == EFFECT_DELAYED_OFF && variant == VARIANT_0) begin
          r.level_request = 1'b1;
          r.level_target = LEVEL_OFF;
          r.level_transition = SHORT_FADE;
        end else if (effect == EFFECT_DELAYED_OFF && variant == VARIANT_1) begin
          r.level_request = 1'b1;
          r.level_target = LEVEL_OFF;
          r.level_transition = NO_FADE;
        end else if (effect == EFFECT_DELAYED_OFF && variant == VARIANT_2) begin
          r.level_request = 1'b1;
          r.level_target = HALF_LEVEL;
          r.level_transition = SHORT_FADE;
        end else if (effect == EFFECT_DYING_LIGHT && variant == VARIANT_0) begin
          r.level_request = 1'b1;
          r.level_target = LEVEL_OFF;
          r.level_transition = DYING_FADE;
        end
        // move to level zero switches the light off
        if (r.level_request && r.level_target == LEVEL_OFF) light_q = 1'b0;
      end
      ACT_RECALL: begin
        if (!scene_q) begin
          light_q = 1'b1;
          r.recall_scene = 1'b1;
          scene_q = 1'b1;
        end
      end
      ACT_TIMED_OFF: begin
        if (on_time_sup && !((guard & TIMED_OFF_GUARD_BIT) && !light_q)) begin
          if (off_wait_q != 16'd0 && !light_q && wait_arg < off_wait_q) begin
            off_wait_q = wait_arg;
          end else begin
            if (on_arg > on_time_q) on_time_q = on_arg;
            if (desired_upd) light_q = 1'b1;
            off_wait_q = wait_arg;
          end
          if (off_wait_q != 16'd0 && on_time_q != 16'd0) counting_q = 1'b1;
        end
      end
      ACT_TICK: begin
        if (counting_q) begin
          if (light_q) begin
            if (on_time_q != 16'd0) begin
              on_time_q = on_time_q - 16'd1;
            end else begin
              off_wait_q = 16'd0;
              light_q = 1'b0;
              counting_q = 1'b0;
            end
          end else begin
            if (off_wait_q != 16'd0) off_wait_q = off_wait_q - 16'd1;
            else counting_q = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.light_on = light_q;
    r.on_time = on_time_q;
    r.off_wait = off_wait_q;
    r.scene_control = scene_q;
    r.timer_running = counting_q;
    return r;
  endfunction

  function automatic string describe(input light_result_t r);
    return $sformatf("on=%0d ton=%0d twait=%0d scene=%0d run=%0d lvl=%0d tgt=%0d tr=%0d st=%0d rc=%0d",
                     r.light_on, r.on_time, r.off_wait, r.scene_control, r.timer_running,
                     r.level_request, r.level_target, r.level_transition, r.store_scene,
                     r.recall_scene);
  endfunction

  // track registers, predict each accepted command and check each accepted result
  always @(posedge clk) begin
    light_result_t seen;
    light_result_t want;
    if (!rst_n) begin
      light_q = 1'b0;
      on_time_q = 16'd0;
      off_wait_q = 16'd0;
      scene_q = 1'b1;
      counting_q = 1'b0;
      on_time_sup = 1'b1;
      off_wait_sup = 1'b1;
      desired_upd = 1'b1;
      expected_light_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ON_TIME_SUP:  on_time_sup = cfg_wdata;
          CFG_OFF_WAIT_SUP: off_wait_sup = cfg_wdata;
          CFG_DESIRED_UPD:  desired_upd = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_light_q.push_back(predict_command(in_action, in_accept_only_when_on,
                                                   in_on_time_arg, in_off_wait_arg,
                                                   in_effect_id, in_effect_variant));
      end
      if (out_valid && !out_stall) begin
        seen = {out_light_on, out_on_time_now, out_off_wait_now, out_scene_control,
                out_timer_running, out_level_request, out_level_target,
                out_level_transition, out_store_scene, out_recall_scene};
        if (expected_light_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result with no command pending: %s", describe(seen));
        end else begin
          want = expected_light_q.pop_front();
          if (seen !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("result mismatch, expected %s", describe(want));
              $display("                 actual   %s", describe(seen));
            end
          end
        end
      end
    end
    mismatch_count <= errors;
    outstanding <= expected_light_q.size();
  end

  initial begin
    errors = 0;
    mismatch_count = 0;
    outstanding = 0;
  end

endmodule

@@ dv/tb_top.sv @@
// testbench top for the on/off timed light control core: clock, reset, stimulus, verdict
// depends on ootlc_pkg, the core and light_control_checker
`timescale 1ns / 1ps

module tb_top;
  import ootlc_pkg::*;

  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 60000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic                 cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [2:0]           in_action;
  logic                 in_accept_only_when_on;
  logic [15:0]          in_on_time_arg;
  logic [15:0]          in_off_wait_arg;
  logic [7:0]           in_effect_id;
  logic [7:0]           in_effect_variant;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_light_on;
  logic [15:0]          out_on_time_now;
  logic [15:0]          out_off_wait_now;
  logic                 out_scene_control;
  logic                 out_timer_running;
  logic                 out_level_request;
  logic [7:0]           out_level_target;
  logic [7:0]           out_level_transition;
  logic                 out_store_scene;
  logic                 out_recall_scene;

  int mismatch_count;
  int outstanding;
  int send_gap_pct;
  int recv_stall_pct;
  int commands_sent;
  int cycle_count;

  on_off_timed_light_control_core i_dut (.*);

  light_control_checker i_checker (.*);

  always #1 clk = ~clk;

  // result side back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // one command transaction, entered and left just after a falling edge
  task automatic send_command(input logic [2:0] act, input logic guard,
                              input logic [15:0] on_arg, input logic [15:0] wait_arg,
                              input logic [7:0] effect, input logic [7:0] variant);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_accept_only_when_on <= guard;
    in_on_time_arg <= on_arg;
    in_off_wait_arg <= wait_arg;
    in_effect_id <= effect;
    in_effect_variant <= variant;
    do @(posedge clk); while (in_stall);
    commands_sent++;
    @(negedge clk);
  endtask

  // drop valid and wait for every result to drain
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // write all three registers, only while idle
  task automatic apply_settings(input logic on_sup, input logic wait_sup, input logic upd);
    logic [2:0] vals;
    vals = {upd, wait_sup, on_sup};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_wdata <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_time();
    if ($urandom_range(0, 99) < 75) return 16'($urandom_range(0, 6));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [7:0] pick_effect();
    if ($urandom_range(0, 99) < 70) return 8'($urandom_range(0, 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_variant();
    if ($urandom_range(0, 99) < 70) return 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [2:0] pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return ACT_TICK;
    if (r < 45) return ACT_TIMED_OFF;
    if (r < 53) return ACT_ON;
    if (r < 61) return ACT_OFF;
    if (r < 69) return ACT_TOGGLE;
    if (r < 81) return ACT_OFF_EFFECT;
    if (r < 97) return ACT_RECALL;
    return ACT_UNUSED;
  endfunction

  task automatic send_random_command();
    send_command(pick_action(), 1'($urandom_range(0, 1)), pick_time(), pick_time(),
                 pick_effect(), pick_variant());
  endtask

  // mostly timed-off followed by a random number of ticks, up to enough to run the countdown out
  task automatic run_random_segment(input int count);
    int stop_at;
    int on_len;
    int wait_len;
    int ticks;
    stop_at = commands_sent + count;
    while (commands_sent < stop_at) begin
      if ($urandom_range(0, 99) < 60) begin
        on_len = $urandom_range(1, 6);
        wait_len = $urandom_range(1, 6);
        if ($urandom_range(0, 3) == 0) send_command(ACT_ON, 1'b0, 16'd0, 16'd0, 8'd0, 8'd0);
        send_command(ACT_TIMED_OFF, 1'($urandom_range(0, 1)), 16'(on_len), 16'(wait_len),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        ticks = $urandom_range(0, on_len + wait_len + 4);
        for (int t = 0; t < ticks; t++) begin
          if ($urandom_range(0, 9) == 0) send_random_command();
          else send_command(ACT_TICK, 1'($urandom_range(0, 1)), pick_time(), pick_time(),
                            pick_effect(), pick_variant());
        end
      end else begin
        send_random_command();
      end
    end
    drain();
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= 1'b0;
    in_valid <= 1'b0;
    in_action <= ACT_ON;
    in_accept_only_when_on <= 1'b0;
    in_on_time_arg <= 16'd0;
    in_off_wait_arg <= 16'd0;
    in_effect_id <= 8'd0;
    in_effect_variant <= 8'd0;
    out_stall <= 1'b0;
    cycle_count <= 0;
    commands_sent = 0;
    send_gap_pct = 36;
    recv_stall_pct = 52;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: scene handling, timed-off countdown, guard, effects, unused code
    send_command(ACT_RECALL, 1'b0, 16'd0, 16'd0, 8'd0, 8'd0);
    send_command(ACT_ON, 1'b0, 16'd0, 16'd0, 8'd0, 8'd0);
    send_command(ACT_TIMED_OFF, 1'b1, 16'd3, 16'd2, 8'd0, 8'd0);
    repeat (4) send_command(ACT_TICK, 1'b0, 16'd0, 16'd0, 8'd0, 8'd0);
    send_command(ACT_TICK, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    send_command(ACT_TIMED_OFF, 1'b1, 16'd5, 16'd5, 8'd0, 8'd0);
    send_command(ACT_TIMED_OFF, 1'b0, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    send_command(ACT_OFF, 1'b0, 16'd0, 16'd0, 8'd0, 8'd0);
    send_command(ACT_TICK, 1'b0, 16'd0, 16'd0, 8'd0, 8'd0);
    send_command(ACT_TIMED_OFF, 1'b0, 16'd0, 16'd5, 8'd0, 8'd0);
    send_command(ACT_TOGGLE, 1'b0, 16'd0, 16'd0, 8'd0, 8'd0);
    send_command(ACT_TOGGLE, 1'b0, 16'd0, 16'd0, 8'd0, 8'd0);
    send_command(ACT_OFF_EFFECT, 1'b0, 16'd0, 16'd0, EFFECT_DELAYED_OFF, VARIANT_0);
    send_command(ACT_OFF_EFFECT, 1'b0, 16'd0, 16'd0, EFFECT_DELAYED_OFF, VARIANT_1);
    send_command(ACT_RECALL, 1'b0, 16'd0, 16'd0, 8'd0, 8'd0);
    send_command(ACT_OFF_EFFECT, 1'b0, 16'd0, 16'd0, EFFECT_DELAYED_OFF, VARIANT_2);
    send_command(ACT_OFF_EFFECT, 1'b0, 16'd0, 16'd0, EFFECT_DYING_LIGHT, VARIANT_0);
    send_command(ACT_OFF_EFFECT, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    send_command(ACT_RECALL, 1'b0, 16'd0, 16'd0, 8'd0, 8'd0);
    send_command(ACT_UNUSED, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    send_command(ACT_TICK, 1'b0, 16'd0, 16'd0, 8'd0, 8'd0);
    drain();

    // random phases over several register settings
    run_random_segment(67);
    apply_settings(1'b0, 1'b0, 1'b0);
    run_random_segment(67);
    send_gap_pct = 52;
    recv_stall_pct = 36;
    apply_settings(1'b1, 1'b0, 1'b1);
    run_random_segment(67);
    apply_settings(1'b1, 1'b1, 1'b0);
    run_random_segment(67);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    apply_settings(1'b1, 1'b0, 1'b0);
    run_random_segment(67);
    apply_settings(1'b1, 1'b1, 1'b1);
    run_random_segment(67);

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
